FILE: rtl/ecf_pkg.sv
// Package for the elevation cell fusion block: payload structs, constants,
// controller/datapath command and status types. No dependencies.
package ecf_pkg;

  localparam int unsigned VarW   = 48;
  localparam int unsigned PosW   = 32;
  localparam int unsigned CsW    = 20;
  localparam int unsigned NumW   = 98;   // product sum plus rounding term
  localparam int unsigned SumW   = 49;   // P + R
  localparam int unsigned CellsXDef = 256;
  localparam int unsigned CellsYDef = 256;

  localparam logic [VarW-1:0] VarMeasMin  = 48'd10995;
  localparam logic [VarW-1:0] VarOldFloor = 48'd110;
  localparam logic [VarW-1:0] VarNewFloor = 48'd10995;
  localparam logic [VarW-1:0] DefVarRst   = 48'd10995116278;
  localparam logic [CsW-1:0]  CellSizeRst = 20'd6554;

  localparam logic CfgDefVar   = 1'b0;
  localparam logic CfgCellSize = 1'b1;

  typedef struct packed {
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_y;
    logic signed [31:0] height;
    logic [47:0]        meas_variance;
    logic               variance_ok;
  } ecf_in_t;

  typedef struct packed {
    logic               inside_res;
    logic [7:0]         cell_col;
    logic [7:0]         cell_row;
    logic signed [31:0] fused_height;
    logic [47:0]        fused_variance;
    logic               first_hit;
  } ecf_out_t;

  // Datapath commands from the controller
  typedef struct packed {
    logic load;       // capture input item
    logic idx_start;  // start index divisions
    logic rd;         // issue memory read
    logic mul_step;   // advance product accumulation
    logic div_start;  // start variance/mean divisions
    logic commit;     // write cell and build result
  } ecf_cmd_t;

  typedef struct packed {
    logic idx_done;
    logic in_grid;
    logic valid_hit;
    logic mul_done;
    logic div_done;
  } ecf_sts_t;

endpackage

FILE: rtl/ecf_ctrl.sv
// Controller FSM of the elevation cell fusion block.
// Depends on ecf_pkg.
module ecf_ctrl
  import ecf_pkg::*;
(
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  output logic     in_ready_o,
  input  logic     out_busy_i,
  output logic     out_push_o,
  output ecf_cmd_t cmd_o,
  input  ecf_sts_t sts_i
);

  localparam logic [2:0] StIdle = 3'd0;
  localparam logic [2:0] StIdx  = 3'd1;
  localparam logic [2:0] StRd   = 3'd2;
  localparam logic [2:0] StMul  = 3'd3;
  localparam logic [2:0] StDiv  = 3'd4;
  localparam logic [2:0] StOut  = 3'd5;
  localparam logic [2:0] StChk  = 3'd6;

  logic [2:0] state_q, state_d;

  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    out_push_o = 1'b0;
    unique case (state_q)
      StIdle: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = StIdx;
        end
      end
      StIdx: begin
        cmd_o.idx_start = 1'b1;
        state_d         = StChk;
      end
      StChk: begin
        if (sts_i.idx_done) begin
          if (sts_i.in_grid) begin
            cmd_o.rd = 1'b1;
            state_d  = StRd;
          end else begin
            state_d = StOut;
          end
        end
      end
      StRd: begin
        if (sts_i.valid_hit) begin
          cmd_o.mul_step = 1'b1;
          state_d        = StMul;
        end else begin
          state_d = StOut;
        end
      end
      StMul: begin
        cmd_o.mul_step = 1'b1;
        if (sts_i.mul_done) begin
          cmd_o.mul_step  = 1'b0;
          cmd_o.div_start = 1'b1;
          state_d         = StDiv;
        end
      end
      StDiv: begin
        if (sts_i.div_done) state_d = StOut;
      end
      StOut: begin
        if (!out_busy_i) begin
          cmd_o.commit = 1'b1;
          out_push_o   = 1'b1;
          state_d      = StIdle;
        end
      end
      default: state_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) state_q <= StIdle;
    else         state_q <= state_d;
  end

endmodule

FILE: rtl/ecf_div.sv
// Radix-2 restoring divider, one quotient bit per cycle.
// Depends on ecf_pkg.
module ecf_div
  import ecf_pkg::*;
#(
  parameter int unsigned NW = NumW,
  parameter int unsigned DW = SumW,
  parameter int unsigned QW = 64
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          start_i,
  input  logic [NW-1:0] num_i,
  input  logic [DW-1:0] den_i,
  output logic          busy_o,
  output logic [QW-1:0] quo_o
);

  localparam int unsigned CntW = $clog2(NW + 1);

  logic [NW-1:0]   num_q;
  logic [DW-1:0]   den_q;
  logic [DW:0]     rem_q;
  logic [QW-1:0]   quo_q;
  logic [CntW-1:0] cnt_q;
  logic [DW:0]     shl;
  logic            ge;

  assign shl = {rem_q[DW-1:0], num_q[NW-1]};
  assign ge  = shl >= {1'b0, den_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else if (start_i) begin
      cnt_q <= CntW'(NW);
    end else if (cnt_q != '0) begin
      cnt_q <= cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      num_q <= num_i;
      den_q <= den_i;
      rem_q <= '0;
      quo_q <= '0;
    end else if (cnt_q != '0) begin
      num_q <= num_q << 1;
      rem_q <= ge ? (shl - {1'b0, den_q}) : shl;
      quo_q <= {quo_q[QW-2:0], ge};
    end
  end

  assign busy_o = cnt_q != '0;
  assign quo_o  = quo_q;

endmodule

FILE: rtl/ecf_dp.sv
// Datapath: cell index, cell memories, product accumulation and dividers.
// Depends on ecf_pkg and ecf_div.
module ecf_dp
  import ecf_pkg::*;
#(
  parameter int unsigned CellsX = CellsXDef,
  parameter int unsigned CellsY = CellsYDef
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  ecf_in_t         in_i,
  input  logic [VarW-1:0] def_var_i,
  input  logic [CsW-1:0]  cell_size_i,
  input  ecf_cmd_t        cmd_i,
  output ecf_sts_t        sts_o,
  output ecf_out_t        res_o
);

  localparam int unsigned XW    = $clog2(CellsX);
  localparam int unsigned YW    = $clog2(CellsY);
  localparam int unsigned AW    = XW + YW;
  localparam int unsigned Depth = 1 << AW;   // {col, row} address space
  localparam int unsigned LenW  = CsW + 14;  // n*cs, n <= 16384
  localparam int unsigned TW    = LenW + 2;  // signed doubled span

  ecf_in_t         in_q;
  logic [VarW-1:0] r_q;

  // ---- index: twod = n*cs - 2*pos, idx = twod / (2*cs) ----
  logic [LenW-1:0]        lenx, leny;
  logic signed [TW-1:0]   twx, twy;
  logic                   inx, iny;
  logic [XW-1:0]          col_idx;
  logic [YW-1:0]          row_idx;
  logic                   inside_q;
  logic [TW-1:0]          qx, qy;
  logic                   bx, by;
  logic                   idx_pend_q;
  logic                   clr_busy_q;

  assign lenx = LenW'(CellsX) * LenW'(cell_size_i);
  assign leny = LenW'(CellsY) * LenW'(cell_size_i);
  assign twx  = $signed({2'b00, lenx}) - ($signed(TW'(in_q.pos_x)) <<< 1);
  assign twy  = $signed({2'b00, leny}) - ($signed(TW'(in_q.pos_y)) <<< 1);
  assign inx  = (cell_size_i != '0) && (twx >= 0) && (twx < $signed({1'b0, lenx, 1'b0}));
  assign iny  = (cell_size_i != '0) && (twy >= 0) && (twy < $signed({1'b0, leny, 1'b0}));

  ecf_div #(.NW(TW), .DW(CsW + 1), .QW(TW)) u_divx (
    .clk_i, .rst_ni, .start_i(cmd_i.idx_start), .num_i(TW'(twx)),
    .den_i({cell_size_i, 1'b0}), .busy_o(bx), .quo_o(qx));
  ecf_div #(.NW(TW), .DW(CsW + 1), .QW(TW)) u_divy (
    .clk_i, .rst_ni, .start_i(cmd_i.idx_start), .num_i(TW'(twy)),
    .den_i({cell_size_i, 1'b0}), .busy_o(by), .quo_o(qy));

  // held until the clearing sweep is over as well
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni)             idx_pend_q <= 1'b0;
    else if (cmd_i.idx_start) idx_pend_q <= 1'b1;
    else if (cmd_i.rd || (idx_pend_q && !bx && !by && !clr_busy_q)) idx_pend_q <= 1'b0;
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      in_q <= in_i;
      r_q  <= (in_i.variance_ok && in_i.meas_variance > VarMeasMin) ?
              in_i.meas_variance : def_var_i;
    end
    if (cmd_i.idx_start) inside_q <= inx && iny;
  end

  assign col_idx = (qx >= TW'(CellsX)) ? XW'(CellsX - 1) : qx[XW-1:0];
  assign row_idx = (qy >= TW'(CellsY)) ? YW'(CellsY - 1) : qy[YW-1:0];

  logic [AW-1:0] addr_q;
  logic [7:0]    col8_q, row8_q;
  always_ff @(posedge clk_i) begin
    if (cmd_i.rd) begin
      addr_q <= {col_idx, row_idx};
      col8_q <= 8'(col_idx);
      row8_q <= 8'(row_idx);
    end
  end

  // ---- cell memories with valid bits cleared by a sweep ----
  logic [PosW-1:0] mean_mem [Depth];
  logic [VarW-1:0] var_mem  [Depth];
  logic            vld_mem  [Depth];
  logic [PosW-1:0] mean_rd_q;
  logic [VarW-1:0] var_rd_q;
  logic            vld_rd_q;
  logic            wr_en;
  logic [PosW-1:0] wr_mean;
  logic [VarW-1:0] wr_var;
  logic [AW-1:0]   clr_addr_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_busy_q <= 1'b1;
      clr_addr_q <= '0;
    end else if (clr_busy_q) begin
      clr_addr_q <= clr_addr_q + 1'b1;
      if (clr_addr_q == AW'(Depth - 1)) clr_busy_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.rd) begin
      mean_rd_q <= mean_mem[{col_idx, row_idx}];
      var_rd_q  <= var_mem[{col_idx, row_idx}];
      vld_rd_q  <= vld_mem[{col_idx, row_idx}];
    end
    if (wr_en) begin
      mean_mem[addr_q] <= wr_mean;
      var_mem[addr_q]  <= wr_var;
    end
    if (clr_busy_q)  vld_mem[clr_addr_q] <= 1'b0;
    else if (wr_en)  vld_mem[addr_q]     <= 1'b1;
  end

  // ---- products over cycles: one 48x16 partial per step, three per product ----
  logic [VarW-1:0]  p_fl;
  logic [SumW-1:0]  sum;
  logic [1:0]       psel_q, chunk_q;
  logic [NumW-1:0]  pr_q, mnum_q;
  logic [VarW-1:0]  ma, mb_;
  logic [15:0]      mpart;
  logic [VarW+15:0] prod;
  logic [NumW-1:0]  prod_sh;

  assign p_fl = (var_rd_q < VarOldFloor) ? VarOldFloor : var_rd_q;
  assign sum  = {1'b0, p_fl} + {1'b0, r_q};

  always_comb begin
    unique case (psel_q)
      2'd0:    begin ma = p_fl; mb_ = r_q; end
      2'd1:    begin ma = r_q;  mb_ = {16'd0, mean_rd_q ^ 32'h8000_0000}; end
      default: begin ma = p_fl; mb_ = {16'd0, in_q.height ^ 32'h8000_0000}; end
    endcase
    unique case (chunk_q)
      2'd0:    mpart = mb_[15:0];
      2'd1:    mpart = mb_[31:16];
      default: mpart = mb_[47:32];
    endcase
  end
  assign prod = ma * mpart;

  always_comb begin
    unique case (chunk_q)
      2'd0:    prod_sh = NumW'(prod);
      2'd1:    prod_sh = NumW'(prod) << 16;
      default: prod_sh = NumW'(prod) << 32;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      psel_q  <= '0;
      chunk_q <= '0;
    end else if (cmd_i.rd) begin
      psel_q  <= '0;
      chunk_q <= '0;
    end else if (cmd_i.mul_step) begin
      if (chunk_q == 2'd2) begin
        chunk_q <= '0;
        psel_q  <= psel_q + 1'b1;
      end else begin
        chunk_q <= chunk_q + 1'b1;
      end
    end
  end

  // rounding term enters with the first partial of each numerator
  always_ff @(posedge clk_i) begin
    if (cmd_i.mul_step) begin
      unique case (psel_q)
        2'd0:    pr_q   <= (chunk_q == 2'd0) ? (NumW'(sum >> 1) + prod_sh) : (pr_q + prod_sh);
        2'd1:    mnum_q <= (chunk_q == 2'd0) ? (NumW'(sum >> 1) + prod_sh) : (mnum_q + prod_sh);
        default: mnum_q <= mnum_q + prod_sh;
      endcase
    end
  end

  logic [63:0] qv, qm;
  logic        bv, bm;
  ecf_div #(.NW(NumW), .DW(SumW), .QW(64)) u_divv (
    .clk_i, .rst_ni, .start_i(cmd_i.div_start), .num_i(pr_q), .den_i(sum),
    .busy_o(bv), .quo_o(qv));
  ecf_div #(.NW(NumW), .DW(SumW), .QW(64)) u_divm (
    .clk_i, .rst_ni, .start_i(cmd_i.div_start), .num_i(mnum_q), .den_i(sum),
    .busy_o(bm), .quo_o(qm));

  logic div_pend_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni)              div_pend_q <= 1'b0;
    else if (cmd_i.div_start) div_pend_q <= 1'b1;
    else if (div_pend_q && !bv && !bm) div_pend_q <= 1'b0;
  end

  logic [VarW-1:0] vn;
  assign vn = (qv < 64'(VarNewFloor)) ? VarNewFloor : qv[VarW-1:0];

  // ---- commit and result ----
  logic first;
  assign first   = !vld_rd_q;
  assign wr_en   = cmd_i.commit && inside_q;
  assign wr_mean = first ? in_q.height : (qm[31:0] ^ 32'h8000_0000);
  assign wr_var  = first ? r_q : vn;

  always_comb begin
    res_o = '0;
    if (inside_q) begin
      res_o.inside_res     = 1'b1;
      res_o.cell_col       = col8_q;
      res_o.cell_row       = row8_q;
      res_o.fused_height   = wr_mean;
      res_o.fused_variance = wr_var;
      res_o.first_hit      = first;
    end
  end

  assign sts_o.idx_done  = idx_pend_q && !bx && !by && !clr_busy_q;
  assign sts_o.in_grid   = inside_q;
  assign sts_o.valid_hit = vld_rd_q;
  assign sts_o.mul_done  = psel_q == 2'd3;
  assign sts_o.div_done  = div_pend_q && !bv && !bm;

endmodule

FILE: rtl/elevation_cell_kalman_fusion.sv
// Elevation cell fusion: one height point per beat is mapped to a cell of a
// CELLS_X by CELLS_Y grid centred on the origin and fused into that cell by a
// scalar Kalman update (mean and variance kept in on-chip memories). Items are
// processed one at a time: the cell index comes from two 36-step radix-2
// dividers in parallel, the products from one 48x16 multiplier (three partials
// per product) and the mean and variance quotients from two 98-step radix-2
// dividers; a point outside the grid skips the products and quotients, and a
// first hit skips them as well. A result beat that is not taken holds the next
// one back. After reset a sweep over all 2^(clog2(CELLS_X)+clog2(CELLS_Y))
// addresses clears the valid bits; an item accepted meanwhile waits for it.
// Configuration writes are taken any time and must be done while idle.
// Depends on ecf_pkg, ecf_ctrl, ecf_dp, ecf_div.
module elevation_cell_kalman_fusion
  import ecf_pkg::*;
#(
  parameter int unsigned CellsX = CellsXDef,
  parameter int unsigned CellsY = CellsYDef
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  ecf_in_t     in_data_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output ecf_out_t    out_data_o,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [0:0]  cfg_index_i,
  input  logic [47:0] cfg_data_i
);

  ecf_cmd_t        cmd;
  ecf_sts_t        sts;
  ecf_out_t        res;
  logic            push;
  logic [VarW-1:0] def_var_q;
  logic [CsW-1:0]  cell_size_q;

  // configuration registers
  assign cfg_ready_o = 1'b1;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      def_var_q   <= DefVarRst;
      cell_size_q <= CellSizeRst;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        CfgDefVar:   def_var_q   <= cfg_data_i;
        CfgCellSize: cell_size_q <= cfg_data_i[CsW-1:0];
        default:     ;
      endcase
    end
  end

  ecf_ctrl u_ctrl (
    .clk_i, .rst_ni, .in_valid_i, .in_ready_o,
    .out_busy_i(out_valid_o), .out_push_o(push), .cmd_o(cmd), .sts_i(sts));

  ecf_dp #(.CellsX(CellsX), .CellsY(CellsY)) u_dp (
    .clk_i, .rst_ni, .in_i(in_data_i), .def_var_i(def_var_q),
    .cell_size_i(cell_size_q), .cmd_i(cmd), .sts_o(sts), .res_o(res));

  // output register: holds the result beat until taken
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni)                   out_valid_o <= 1'b0;
    else if (push)                 out_valid_o <= 1'b1;
    else if (out_ready_i)          out_valid_o <= 1'b0;
  end
  always_ff @(posedge clk_i) begin
    if (push) out_data_o <= res;
  end

`ifndef SYNTHESIS
  a_push_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push |-> !out_valid_o) else $error("result pushed over pending beat");
  a_no_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_ready_o |-> !cmd.commit) else $error("accept while committing");
  a_outside_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (push && !res.inside_res) |-> (res.first_hit == 1'b0))
    else $error("outside point marked first hit");
`endif

endmodule
